/* rtl/dlpg_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlpg_pkg: shared constants of the drag line point generator
// Default sizes, spacing register format and its reset value.
// ----------------------------------------------------------------------------
package dlpg_pkg;

    localparam int DEF_MAX_POINTS = 64;
    localparam int DEF_COORD_BITS = 24;

    localparam int SPACING_W = 23;
    localparam logic [SPACING_W-1:0] SPACING_RESET = 23'd256;

    // Depth of the segment command queue between front and back.
    localparam int CMD_QUEUE_DEPTH = 2;

endpackage

/* rtl/dlpg_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlpg_fifo: segment command queue
// Two-entry queue that decouples the front end from the point emitter.
// ----------------------------------------------------------------------------
module dlpg_fifo import dlpg_pkg::*; #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_push_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_pop_data,
    output logic             o_empty
);

    localparam int PW = $clog2(CMD_QUEUE_DEPTH);

    logic [WIDTH-1:0] r_mem [CMD_QUEUE_DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [PW:0]      r_count, n_count;

    assign o_full     = (r_count == (PW+1)'(CMD_QUEUE_DEPTH));
    assign o_empty    = (r_count == '0);
    assign o_pop_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push && !o_full) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop && !o_empty) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if ((i_push && !o_full) && !(i_pop && !o_empty)) begin
            n_count = r_count + 1'b1;
        end else if (!(i_push && !o_full) && (i_pop && !o_empty)) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

endmodule

/* rtl/dlpg_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlpg_front: segment front end
// Takes a segment, finds its length by a bit-serial square root and its
// segment count by a restoring division, and queues a segment command.
// ----------------------------------------------------------------------------
module dlpg_front import dlpg_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int SEG_W      = $clog2(MAX_POINTS),
    parameter int CMD_W      = 3 * (2 * COORD_BITS + 1) + SEG_W + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_start_z,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic signed [COORD_BITS-1:0] i_end_z,
    input  logic [SPACING_W-1:0]         i_spacing,
    output logic                         o_push,
    output logic [CMD_W-1:0]             o_push_data,
    input  logic                         i_full
);

    localparam int CB   = COORD_BITS;
    localparam int SQW  = 2 * CB + 2;            // sum of squares
    localparam int LW   = CB + 1;                // length
    localparam int RW   = LW + 3;                // root remainder
    localparam int NW0  = (LW + 1 > SPACING_W) ? LW + 1 : SPACING_W;
    localparam int NW   = NW0 + 1;               // division numerator
    localparam int DW   = SPACING_W + 1;         // divisor 2*spacing
    localparam int STW  = $clog2(NW + 1);        // step counter
    localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(MAX_POINTS - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SQ   = 3'd1;
    localparam logic [2:0] ST_ROOT = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_PUSH = 3'd4;

    logic [2:0]               r_state;
    logic [STW-1:0]           r_step;
    logic signed [CB-1:0]     r_start [3];
    logic [CB-1:0]            r_mag   [3];
    logic                     r_neg   [3];
    logic [2*CB-1:0]          r_prod;
    logic [SQW-1:0]           r_rad;
    logic [RW-1:0]            r_rem;
    logic [LW-1:0]            r_root;
    logic [NW-1:0]            r_num;
    logic [DW:0]              r_drem;
    logic [SEG_W-1:0]         r_seg;
    logic                     r_capped;

    logic signed [CB:0]       w_diff [3];
    logic [CB-1:0]            w_sq_mag;
    logic [RW-1:0]            w_rem_sh;
    logic [RW-1:0]            w_trial;
    logic [DW:0]              w_drem_sh;
    logic [DW:0]              w_den;

    assign o_busy = (r_state != ST_IDLE);
    assign o_push = (r_state == ST_PUSH) && !i_full;
    assign o_push_data = {r_start[0], r_mag[0], r_neg[0],
                          r_start[1], r_mag[1], r_neg[1],
                          r_start[2], r_mag[2], r_neg[2],
                          r_seg, r_capped};

    always_comb begin
        w_diff[0] = {i_end_x[CB-1], i_end_x} - {i_start_x[CB-1], i_start_x};
        w_diff[1] = {i_end_y[CB-1], i_end_y} - {i_start_y[CB-1], i_start_y};
        w_diff[2] = {i_end_z[CB-1], i_end_z} - {i_start_z[CB-1], i_start_z};
    end

    always_comb begin
        unique case (r_step[1:0])
            2'd0:    w_sq_mag = r_mag[0];
            2'd1:    w_sq_mag = r_mag[1];
            default: w_sq_mag = r_mag[2];
        endcase
    end

    assign w_rem_sh  = {r_rem[RW-3:0], r_rad[SQW-1 -: 2]};
    assign w_trial   = {1'b0, r_root, 2'b01};
    assign w_drem_sh = {r_drem[DW-1:0], r_num[NW-1]};
    assign w_den     = {1'b0, i_spacing, 1'b0};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_state <= ST_SQ;
                        r_step  <= '0;
                    end
                end
                ST_SQ: begin
                    if (r_step == STW'(3)) begin
                        r_state <= ST_ROOT;
                        r_step  <= '0;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_ROOT: begin
                    if (r_step == STW'(LW - 1)) begin
                        r_step <= '0;
                        // Zero spacing or a zero length skips the count division.
                        if (i_spacing == '0 ||
                            (!(w_rem_sh >= w_trial) && r_root[LW-2:0] == '0)) begin
                            r_state <= ST_PUSH;
                        end else begin
                            r_state <= ST_DIV;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_DIV: begin
                    if (r_step == STW'(NW - 1)) begin
                        r_state <= ST_PUSH;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                ST_PUSH: begin
                    if (!i_full) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                r_start[0] <= i_start_x;
                r_start[1] <= i_start_y;
                r_start[2] <= i_start_z;
                for (int k = 0; k < 3; k++) begin
                    r_neg[k] <= w_diff[k][CB];
                    r_mag[k] <= w_diff[k][CB] ? CB'(-w_diff[k]) : CB'(w_diff[k]);
                end
                r_rad    <= '0;
                r_rem    <= '0;
                r_root   <= '0;
                r_seg    <= '0;
                r_capped <= 1'b0;
            end
            ST_SQ: begin
                if (r_step != '0) begin
                    r_rad <= r_rad + SQW'(r_prod);
                end
                r_prod <= w_sq_mag * w_sq_mag;
            end
            ST_ROOT: begin
                r_rad <= {r_rad[SQW-3:0], 2'b00};
                if (w_rem_sh >= w_trial) begin
                    r_rem  <= w_rem_sh - w_trial;
                    r_root <= {r_root[LW-2:0], 1'b1};
                    r_num  <= NW'({r_root[LW-2:0], 1'b1, 1'b0}) + NW'(i_spacing);
                end else begin
                    r_rem  <= w_rem_sh;
                    r_root <= {r_root[LW-2:0], 1'b0};
                    r_num  <= NW'({r_root[LW-2:0], 1'b0, 1'b0}) + NW'(i_spacing);
                end
                r_drem <= '0;
            end
            ST_DIV: begin
                // Quotient bits shift into the numerator register.
                if (w_drem_sh >= w_den) begin
                    r_drem <= w_drem_sh - w_den;
                    r_num  <= {r_num[NW-2:0], 1'b1};
                end else begin
                    r_drem <= w_drem_sh;
                    r_num  <= {r_num[NW-2:0], 1'b0};
                end
                if (r_step == STW'(NW - 1)) begin
                    if ({r_num[NW-2:0], w_drem_sh >= w_den} == '0) begin
                        r_seg <= SEG_W'(1);
                    end else if ({r_num[NW-2:0], w_drem_sh >= w_den} > NW'(SEG_MAX)) begin
                        r_seg    <= SEG_MAX;
                        r_capped <= 1'b1;
                    end else begin
                        r_seg <= SEG_W'({r_num[NW-2:0], w_drem_sh >= w_den});
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/dlpg_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlpg_back: point emitter
// Divides each axis magnitude by the segment count, then steps a quotient
// and remainder per axis to emit one rounded point per cycle.
// ----------------------------------------------------------------------------
module dlpg_back import dlpg_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS,
    parameter int SEG_W      = $clog2(MAX_POINTS),
    parameter int CMD_W      = 3 * (2 * COORD_BITS + 1) + SEG_W + 1
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_empty,
    input  logic [CMD_W-1:0]             i_cmd,
    output logic                         o_pop,
    output logic                         o_point_valid,
    output logic signed [COORD_BITS-1:0] o_point_x,
    output logic signed [COORD_BITS-1:0] o_point_y,
    output logic signed [COORD_BITS-1:0] o_point_z,
    output logic                         o_last_point,
    output logic                         o_count_capped
);

    localparam int CB  = COORD_BITS;
    localparam int STW = $clog2(CB + 1);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]            r_state;
    logic [STW-1:0]        r_step;
    logic [SEG_W-1:0]      r_idx;
    logic signed [CB-1:0]  r_start [3];
    logic [CB-1:0]         r_quo   [3];   // magnitude, then quotient per point
    logic                  r_neg   [3];
    logic [SEG_W:0]        r_drem  [3];
    logic [CB-1:0]         r_acc   [3];
    logic [SEG_W+1:0]      r_frac  [3];
    logic [SEG_W-1:0]      r_seg;
    logic                  r_capped;
    logic signed [CB-1:0]  r_pt    [3];
    logic                  r_valid;
    logic                  r_last;
    logic                  r_cap_out;

    logic [SEG_W:0]        w_drem_sh [3];
    logic [SEG_W+1:0]      w_frac_sum [3];
    logic [SEG_W+1:0]      w_two_seg;

    assign o_pop          = (r_state == ST_IDLE) && !i_empty;
    assign o_point_valid  = r_valid;
    assign o_point_x      = r_pt[0];
    assign o_point_y      = r_pt[1];
    assign o_point_z      = r_pt[2];
    assign o_last_point   = r_last;
    assign o_count_capped = r_cap_out;
    assign w_two_seg      = {1'b0, r_seg, 1'b0};

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_drem_sh[k]  = {r_drem[k][SEG_W-1:0], r_quo[k][CB-1]};
            w_frac_sum[k] = r_frac[k] + {r_drem[k], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_valid <= 1'b0;
        end else begin
            r_valid <= (r_state == ST_EMIT);
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_state <= (i_cmd[SEG_W:1] == '0) ? ST_EMIT : ST_DIV;
                    end
                end
                ST_DIV: begin
                    if (r_step == STW'(CB - 1)) begin
                        r_state <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (r_idx == r_seg) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                {r_start[0], r_quo[0], r_neg[0],
                 r_start[1], r_quo[1], r_neg[1],
                 r_start[2], r_quo[2], r_neg[2],
                 r_seg, r_capped} <= i_cmd;
                r_step <= '0;
                r_idx  <= '0;
                for (int k = 0; k < 3; k++) begin
                    r_drem[k] <= '0;
                    r_acc[k]  <= '0;
                    r_frac[k] <= {2'b00, i_cmd[SEG_W:1]};
                end
            end
            ST_DIV: begin
                r_step <= r_step + 1'b1;
                for (int k = 0; k < 3; k++) begin
                    if (w_drem_sh[k] >= {1'b0, r_seg}) begin
                        r_drem[k] <= w_drem_sh[k] - {1'b0, r_seg};
                        r_quo[k]  <= {r_quo[k][CB-2:0], 1'b1};
                    end else begin
                        r_drem[k] <= w_drem_sh[k];
                        r_quo[k]  <= {r_quo[k][CB-2:0], 1'b0};
                    end
                end
            end
            ST_EMIT: begin
                r_idx     <= r_idx + 1'b1;
                r_last    <= (r_idx == r_seg);
                r_cap_out <= r_capped;
                for (int k = 0; k < 3; k++) begin
                    r_pt[k] <= r_neg[k] ? r_start[k] - $signed(r_acc[k])
                                        : r_start[k] + $signed(r_acc[k]);
                    // Round half away: carry when the remainder reaches 2*seg.
                    if (w_frac_sum[k] >= w_two_seg) begin
                        r_frac[k] <= w_frac_sum[k] - w_two_seg;
                        r_acc[k]  <= r_acc[k] + r_quo[k] + 1'b1;
                    end else begin
                        r_frac[k] <= w_frac_sum[k];
                        r_acc[k]  <= r_acc[k] + r_quo[k];
                    end
                end
            end
            default: begin
            end
        endcase
    end

endmodule

/* rtl/drag_line_point_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// drag_line_point_generator_unit: evenly spaced points on a line segment
// Emits points from start to end inclusive at about the programmed spacing.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                    Payload
//  segment   in         i_start && !o_busy           i_start_*, i_end_*
//  point     out        o_point_valid (1 cycle)      o_point_*, o_last_point,
//                                                    o_count_capped
//  spacing   in         i_cfg_we                     i_cfg_wdata
//
//  After it accepts an item the front end stays busy through its squares,
//  square root, count division and queue push steps; the division is
//  skipped when the spacing or the length is zero. The point emitter takes
//  the command, runs the per-axis division (skipped for a single-point
//  command) and then emits one point per cycle. When the emitter falls
//  behind, the front end waits in its push state while the two-entry
//  command queue is full. Reset is synchronous, active low, and clears all
//  control state; spacing returns to 256. Points cannot be held off by the
//  receiver.
// ----------------------------------------------------------------------------
module drag_line_point_generator_unit import dlpg_pkg::*; #(
    parameter int MAX_POINTS = DEF_MAX_POINTS,
    parameter int COORD_BITS = DEF_COORD_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic signed [COORD_BITS-1:0] i_start_x,
    input  logic signed [COORD_BITS-1:0] i_start_y,
    input  logic signed [COORD_BITS-1:0] i_start_z,
    input  logic signed [COORD_BITS-1:0] i_end_x,
    input  logic signed [COORD_BITS-1:0] i_end_y,
    input  logic signed [COORD_BITS-1:0] i_end_z,
    input  logic                         i_cfg_we,
    input  logic [SPACING_W-1:0]         i_cfg_wdata,
    output logic                         o_point_valid,
    output logic signed [COORD_BITS-1:0] o_point_x,
    output logic signed [COORD_BITS-1:0] o_point_y,
    output logic signed [COORD_BITS-1:0] o_point_z,
    output logic                         o_last_point,
    output logic                         o_count_capped
);

    localparam int SEG_W = $clog2(MAX_POINTS);
    // Command: per axis start, magnitude and sign, then count and capped flag.
    localparam int CMD_W = 3 * (2 * COORD_BITS + 1) + SEG_W + 1;

    logic [SPACING_W-1:0] r_spacing;
    logic                 w_push, w_full, w_pop, w_empty;
    logic [CMD_W-1:0]     w_push_data, w_pop_data;

    // The user must write the spacing register only while the block is idle; the block itself does not enforce this.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_spacing <= SPACING_RESET;
        end else if (i_cfg_we) begin
            r_spacing <= i_cfg_wdata;
        end
    end

    dlpg_front #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .SEG_W      (SEG_W),
        .CMD_W      (CMD_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_start_x   (i_start_x),
        .i_start_y   (i_start_y),
        .i_start_z   (i_start_z),
        .i_end_x     (i_end_x),
        .i_end_y     (i_end_y),
        .i_end_z     (i_end_z),
        .i_spacing   (r_spacing),
        .o_push      (w_push),
        .o_push_data (w_push_data),
        .i_full      (w_full)
    );

    dlpg_fifo #(
        .WIDTH (CMD_W)
    ) u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_data),
        .o_full      (w_full),
        .i_pop       (w_pop),
        .o_pop_data  (w_pop_data),
        .o_empty     (w_empty)
    );

    dlpg_back #(
        .MAX_POINTS (MAX_POINTS),
        .COORD_BITS (COORD_BITS),
        .SEG_W      (SEG_W),
        .CMD_W      (CMD_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_empty        (w_empty),
        .i_cmd          (w_pop_data),
        .o_pop          (w_pop),
        .o_point_valid  (o_point_valid),
        .o_point_x      (o_point_x),
        .o_point_y      (o_point_y),
        .o_point_z      (o_point_z),
        .o_last_point   (o_last_point),
        .o_count_capped (o_count_capped)
    );

endmodule

/* rtl/dlpg_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dlpg_checker: port-level checks of the point generator
// Watches the top-level ports and flags broken point runs.
// ----------------------------------------------------------------------------
module dlpg_checker import dlpg_pkg::*; (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_start,
    input logic o_busy,
    input logic o_point_valid,
    input logic o_last_point,
    input logic o_count_capped
);

    // No point leaves the block right after a reset cycle.
    a_quiet_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_point_valid)
        else $error("point strobe right after reset");

    // An accepted item keeps the front end busy on the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy)
        else $error("not busy after accepting an item");

    // Points of one run come in consecutive cycles until the last one.
    a_run_contiguous: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_point_valid && !o_last_point) |=> o_point_valid)
        else $error("gap inside a point run");

    // The capped flag is constant across a run.
    a_capped_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_point_valid && !o_last_point) |=> $stable(o_count_capped))
        else $error("capped flag changed within a run");

endmodule

bind drag_line_point_generator_unit dlpg_checker u_dlpg_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_start        (i_start),
    .o_busy         (o_busy),
    .o_point_valid  (o_point_valid),
    .o_last_point   (o_last_point),
    .o_count_capped (o_count_capped)
);

/* tb/sv/tb_drag_line_point_generator_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_drag_line_point_generator_unit: self-checking bench for the point generator
// Drives segments and spacing settings, predicts every emitted point with an
// exact integer model and checks each point strobe against it in order.
// ----------------------------------------------------------------------------
module tb_drag_line_point_generator_unit;
    import dlpg_pkg::*;

    localparam int CW   = DEF_COORD_BITS;
    localparam int MAXP = DEF_MAX_POINTS;
    localparam logic [CW-1:0] CMAX = {1'b0, {(CW-1){1'b1}}};
    localparam logic [CW-1:0] CMIN = {1'b1, {(CW-1){1'b0}}};

    // One expected point on the output.
    typedef struct packed {
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        logic [CW-1:0] pz;
        logic          last;
        logic          capped;
    } point_t;

    // The scoreboard keeps its own copy of the spacing register and turns
    // each accepted segment into the list of points it must produce.
    class point_scoreboard;
        point_t pending[$];
        logic [SPACING_W-1:0] spacing;
        int mismatches;

        function void set_spacing(logic [SPACING_W-1:0] v);
            spacing = v;
        endfunction

        // Appends one expected point behind those already waiting.
        function void add_expected(point_t p);
            pending.insert(pending.size(), p);
        endfunction

        // Rounded magnitude of d*i/seg, half away from zero.
        function longint unsigned step_of(longint signed d, longint unsigned i,
                                          longint unsigned seg);
            longint unsigned m;
            m = (d < 0) ? longint'(-d) : longint'(d);
            return (2 * m * i + seg) / (2 * seg);
        endfunction

        function void note_segment(logic [CW-1:0] s[3], logic [CW-1:0] e[3]);
            longint signed sv[3], dv[3];
            logic [127:0] sq, lo, hi, mid;
            longint unsigned len, seg, q;
            logic cap;
            point_t p;
            logic [CW-1:0] c[3];
            sq = 0;
            cap = 0;
            for (int k = 0; k < 3; k++) begin
                sv[k] = longint'($signed(s[k]));
                dv[k] = longint'($signed(e[k])) - sv[k];
                sq += 128'(dv[k] * dv[k]);
            end
            // Floor square root by bisection.
            lo = 0;
            hi = 128'd1 << 34;
            while (hi - lo > 1) begin
                mid = lo + ((hi - lo) >> 1);
                if (mid * mid <= sq) lo = mid;
                else hi = mid;
            end
            len = lo[63:0];
            if (spacing == 0 || len == 0) begin
                p.px = s[0]; p.py = s[1]; p.pz = s[2];
                p.last = 1; p.capped = 0;
                add_expected(p);
                return;
            end
            seg = (2 * len + spacing) / (2 * longint'(spacing));
            if (seg < 1) seg = 1;
            if (seg > MAXP - 1) begin
                seg = MAXP - 1;
                cap = 1;
            end
            for (longint unsigned i = 0; i <= seg; i++) begin
                for (int k = 0; k < 3; k++) begin
                    q = step_of(dv[k], i, seg);
                    c[k] = (dv[k] < 0) ? CW'(sv[k] - longint'(q))
                                       : CW'(sv[k] + longint'(q));
                end
                p.px = c[0]; p.py = c[1]; p.pz = c[2];
                p.last = (i == seg);
                p.capped = cap;
                add_expected(p);
            end
        endfunction

        function void check_point(point_t got);
            point_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected point x=%h y=%h z=%h",
                             got.px, got.py, got.pz);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: point exp x=%h y=%h z=%h l=%b c=%b got x=%h y=%h z=%h l=%b c=%b",
                             want.px, want.py, want.pz, want.last, want.capped,
                             got.px, got.py, got.pz, got.last, got.capped);
            end
        endfunction
    endclass

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_start = 0;
    logic o_busy;
    logic signed [CW-1:0] i_start_x = 0, i_start_y = 0, i_start_z = 0;
    logic signed [CW-1:0] i_end_x = 0, i_end_y = 0, i_end_z = 0;
    logic i_cfg_we = 0;
    logic [SPACING_W-1:0] i_cfg_wdata = 0;
    logic o_point_valid;
    logic signed [CW-1:0] o_point_x, o_point_y, o_point_z;
    logic o_last_point, o_count_capped;

    point_scoreboard points_sb;
    longint unsigned cycle_count = 0;

    drag_line_point_generator_unit u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
        .i_start_x(i_start_x), .i_start_y(i_start_y), .i_start_z(i_start_z),
        .i_end_x(i_end_x), .i_end_y(i_end_y), .i_end_z(i_end_z),
        .i_cfg_we(i_cfg_we), .i_cfg_wdata(i_cfg_wdata),
        .o_point_valid(o_point_valid), .o_point_x(o_point_x),
        .o_point_y(o_point_y), .o_point_z(o_point_z),
        .o_last_point(o_last_point), .o_count_capped(o_count_capped)
    );

    always begin
        #10 i_clk = 1;
        #10 i_clk = 0;
    end

    // Every point strobe is checked at the edge that accepts it.
    always @(posedge i_clk) begin
        point_t got;
        if (i_rst_n && o_point_valid) begin
            got.px = o_point_x; got.py = o_point_y; got.pz = o_point_z;
            got.last = o_last_point; got.capped = o_count_capped;
            points_sb.check_point(got);
        end
    end

    // Watchdog: 210+ items, with gaps, fit easily within its limit.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Random idle cycles, mostly short with an occasional long pause.
    task automatic idle_gap();
        int n;
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 200)
                                         : $urandom_range(1, 3);
        repeat (n) @(posedge i_clk);
    endtask

    // Presents one segment and holds it until the block takes it.
    task automatic send_segment(logic [CW-1:0] sx, logic [CW-1:0] sy,
                                logic [CW-1:0] sz, logic [CW-1:0] ex,
                                logic [CW-1:0] ey, logic [CW-1:0] ez);
        logic [CW-1:0] s[3], e[3];
        s = '{sx, sy, sz};
        e = '{ex, ey, ez};
        i_start <= 1;
        i_start_x <= sx; i_start_y <= sy; i_start_z <= sz;
        i_end_x <= ex; i_end_y <= ey; i_end_z <= ez;
        do @(posedge i_clk); while (o_busy);
        points_sb.note_segment(s, e);
        i_start <= 0;
        idle_gap();
    endtask

    // Spacing may only change once the block has drained all points.
    task automatic write_spacing(logic [SPACING_W-1:0] v);
        while (points_sb.pending.size() != 0) @(posedge i_clk);
        repeat (200) @(posedge i_clk);
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        points_sb.set_spacing(v);
    endtask

    function automatic logic [CW-1:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return CMAX;
            1: return CMIN;
            2: return CW'($urandom);
            default: return CW'($signed($urandom_range(0, 8191)) - 4096);
        endcase
    endfunction

    // A random segment, usually with its end near its start, so that at most spacing
    // settings the count lands below the cap and the rounding gets exercised.
    task automatic send_random();
        logic [CW-1:0] sx, sy, sz;
        int span;
        sx = rand_coord(); sy = rand_coord(); sz = rand_coord();
        if ($urandom_range(0, 3) == 0) begin
            send_segment(sx, sy, sz, rand_coord(), rand_coord(), rand_coord());
        end else begin
            span = 1 << $urandom_range(2, 14);
            send_segment(sx, sy, sz,
                         sx + CW'($urandom_range(0, 2 * span) - span),
                         sy + CW'($urandom_range(0, 2 * span) - span),
                         sz + CW'($urandom_range(0, 2 * span) - span));
        end
    endtask

    initial begin
        logic [SPACING_W-1:0] spacings[5];
        points_sb = new();
        points_sb.set_spacing(SPACING_RESET);
        spacings = '{23'd0, 23'h7FFFFF, 23'd1, 23'd64, 23'd1000};
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // Directed: reset spacing, zero length, unit step, extremes, capping.
        send_segment(0, 0, 0, 0, 0, 0);
        send_segment(0, 0, 0, 24'd1024, 0, 0);
        send_segment(24'd100, 24'd200, 24'd300, 24'd100, 24'd200, 24'd300);
        send_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        send_segment(CMAX, CMAX, CMAX, CMIN, CMIN, CMIN);
        send_segment(CMAX, 0, CMIN, CMIN, 0, CMAX);
        send_segment(0, 0, 0, 24'd384, 24'd0, 24'd0);
        send_segment(0, 0, 0, -24'sd640, 24'd128, -24'sd1);
        send_segment(24'd5, 0, 0, 24'd4, 0, 0);
        write_spacing(23'd0);
        send_segment(24'd7, -24'sd7, 24'd1, CMAX, CMIN, 0);
        send_segment(CMIN, CMAX, 0, CMIN, CMAX, 0);
        write_spacing(23'h7FFFFF);
        send_segment(CMIN, CMIN, CMIN, CMAX, CMAX, CMAX);
        send_segment(0, 0, 0, 24'd1, 24'd1, 24'd1);
        write_spacing(23'd1);
        send_segment(0, 0, 0, 24'd62, 0, 0);
        send_segment(0, 0, 0, 24'd63, 0, 0);
        send_segment(0, 0, 0, 24'd64, 0, 0);
        send_segment(0, 0, 0, -24'sd3, -24'sd3, -24'sd3);

        // Random phases, each with its own spacing, extremes included.
        for (int ph = 0; ph < 10; ph++) begin
            if (ph < 5) write_spacing(spacings[ph]);
            else write_spacing(SPACING_W'($urandom_range(1, 4096)));
            repeat (20) send_random();
        end

        while (points_sb.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (points_sb.mismatches == 0 && points_sb.pending.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
